// ===== rtl/crbd_pkg.sv =====
// Shared types and constants for the binary record deframer.
package crbd_pkg;

  localparam int BYTE_W    = 8;
  localparam int FMT_W     = 2;
  localparam int ACNT_W    = 9;
  localparam int DCNT_W    = 11;
  localparam int CHAN_W    = 10;
  localparam int VALUE_W   = 32;
  localparam int PART_W    = 24;
  localparam int CNTR_W    = ACNT_W;
  localparam int WORD_BITS = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = DCNT_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_COUNT = 2'd2;

  // Analog sample encodings.
  localparam logic [FMT_W-1:0] FMT_INT16   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_INT32   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_FLOAT32 = 2'd2;

  // Field phase within a record; the code doubles as the result's field kind.
  typedef enum logic [1:0] {
    PH_SAMPLE  = 2'd0,
    PH_TIME    = 2'd1,
    PH_ANALOG  = 2'd2,
    PH_DIGITAL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         field_kind;
    logic [CHAN_W-1:0]  channel_index;
    logic [VALUE_W-1:0] field_value;
    logic               record_last;
  } out_item_t;

  typedef struct packed {
    logic [FMT_W-1:0]  sample_format;
    logic [ACNT_W-1:0] analog_count;
    logic [DCNT_W-1:0] digital_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        byte_position;
    phase_t            field_phase;
    logic [CNTR_W-1:0] field_counter;
    logic [PART_W-1:0] partial_bytes;
  } deframe_state_t;

endpackage

// ===== rtl/crbd_step.sv =====
// Next-state and result logic for one byte of the record stream.
module crbd_step #(
  parameter int MAX_ANALOG  = 256,
  parameter int MAX_DIGITAL = 1024
) (
  input  crbd_pkg::deframe_state_t st_i,
  input  crbd_pkg::in_item_t       item_i,
  input  crbd_pkg::cfg_t           cfg_i,
  output crbd_pkg::deframe_state_t st_o,
  output logic                     emit_o,
  output crbd_pkg::out_item_t      result_o
);

  localparam int AW = crbd_pkg::ACNT_W;
  localparam int DW = crbd_pkg::DCNT_W;
  localparam int CW = crbd_pkg::CNTR_W;
  localparam int XW = crbd_pkg::CHAN_W;
  localparam int FW = CW + 4;

  logic [AW-1:0]              eff_a;
  logic [DW-1:0]              eff_d;
  logic [7:0]                 words;
  crbd_pkg::deframe_state_t   st;
  logic                       size2;
  logic                       complete;
  logic [31:0]                byte_sh;
  logic [31:0]                value;
  logic [FW-1:0]              first;
  logic [FW-1:0]              rem;
  logic [15:0]                dig_val;
  logic                       a_last;
  logic                       d_last;
  logic                       has_dig;

  assign eff_a = ({4'd0, cfg_i.analog_count} > 13'(MAX_ANALOG)) ?
                 AW'(MAX_ANALOG) : cfg_i.analog_count;
  assign eff_d = ({3'd0, cfg_i.digital_count} > 14'(MAX_DIGITAL)) ?
                 DW'(MAX_DIGITAL) : cfg_i.digital_count;
  assign words   = 8'(({1'b0, eff_d} + 12'd15) >> 4);
  assign has_dig = (words != 8'd0);

  always_comb begin
    // A file start restarts the record before this byte is taken in.
    if (item_i.file_start) begin
      st = '0;
    end else begin
      st = st_i;
    end
  end

  assign size2 = (st.field_phase == crbd_pkg::PH_DIGITAL) ||
                 ((st.field_phase == crbd_pkg::PH_ANALOG) &&
                  (cfg_i.sample_format == crbd_pkg::FMT_INT16));
  assign complete = size2 ? (st.byte_position != 2'd0) : (st.byte_position == 2'd3);

  always_comb begin
    case (st.byte_position)
      2'd0:    byte_sh = {24'd0, item_i.data_byte};
      2'd1:    byte_sh = {16'd0, item_i.data_byte, 8'd0};
      2'd2:    byte_sh = {8'd0, item_i.data_byte, 16'd0};
      default: byte_sh = {item_i.data_byte, 24'd0};
    endcase
  end

  assign value = {8'd0, st.partial_bytes} | byte_sh;

  assign first   = {st.field_counter, 4'd0};
  assign rem     = FW'(eff_d) - first;
  assign a_last  = ((10'(st.field_counter) + 10'd1) >= 10'(eff_a));
  assign d_last  = ((10'(st.field_counter) + 10'd1) >= 10'(words));

  always_comb begin
    if (first >= FW'(eff_d)) begin
      dig_val = 16'd0;
    end else if (rem < FW'(crbd_pkg::WORD_BITS)) begin
      dig_val = value[15:0] & ((16'd1 << rem[3:0]) - 16'd1);
    end else begin
      dig_val = value[15:0];
    end
  end

  always_comb begin
    st_o     = st;
    emit_o   = 1'b0;
    result_o.field_kind    = st.field_phase;
    result_o.channel_index = '0;
    result_o.field_value   = value;
    result_o.record_last   = 1'b0;

    if (!complete) begin
      st_o.partial_bytes = value[crbd_pkg::PART_W-1:0];
      st_o.byte_position = st.byte_position + 2'd1;
    end else begin
      emit_o             = 1'b1;
      st_o.byte_position = 2'd0;
      st_o.partial_bytes = '0;
      unique case (st.field_phase)
        crbd_pkg::PH_SAMPLE: begin
          st_o.field_phase = crbd_pkg::PH_TIME;
        end
        crbd_pkg::PH_TIME: begin
          st_o.field_counter = '0;
          if (eff_a != '0) begin
            st_o.field_phase = crbd_pkg::PH_ANALOG;
          end else if (has_dig) begin
            st_o.field_phase = crbd_pkg::PH_DIGITAL;
          end else begin
            st_o.field_phase     = crbd_pkg::PH_SAMPLE;
            result_o.record_last = 1'b1;
          end
        end
        crbd_pkg::PH_ANALOG: begin
          result_o.channel_index = XW'(st.field_counter);
          if (size2) begin
            result_o.field_value = {{16{value[15]}}, value[15:0]};
          end
          if (a_last) begin
            st_o.field_counter = '0;
            if (has_dig) begin
              st_o.field_phase = crbd_pkg::PH_DIGITAL;
            end else begin
              st_o.field_phase     = crbd_pkg::PH_SAMPLE;
              result_o.record_last = 1'b1;
            end
          end else begin
            st_o.field_counter = st.field_counter + CW'(1);
          end
        end
        crbd_pkg::PH_DIGITAL: begin
          result_o.channel_index = first[crbd_pkg::CHAN_W-1:0];
          result_o.field_value   = {16'd0, dig_val};
          if (d_last) begin
            st_o.field_phase     = crbd_pkg::PH_SAMPLE;
            st_o.field_counter   = '0;
            result_o.record_last = 1'b1;
          end else begin
            st_o.field_counter = st.field_counter + CW'(1);
          end
        end
        default: begin
          st_o.field_phase = crbd_pkg::PH_SAMPLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/comtrade_binary_record_deframer_unit.sv =====
// Top level of the binary record deframer: config, state and result registers.
// A result is registered and is valid on out_valid in the cycle after its completing byte transfer.
// Throughput: one byte per cycle while in_stall is low; at most one result per byte.
// in_stall rises only while a held result waits under out_stall.
// Synchronous active-low reset clears the configuration, record position and out_valid.
module comtrade_binary_record_deframer_unit #(
  parameter int MAX_ANALOG  = 256,
  parameter int MAX_DIGITAL = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crbd_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  crbd_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output crbd_pkg::out_item_t                 out_item
);

  crbd_pkg::cfg_t           cfg_r;
  crbd_pkg::cfg_t           cfg_nxt;
  crbd_pkg::deframe_state_t st_r;
  crbd_pkg::deframe_state_t st_nxt;
  crbd_pkg::deframe_state_t step_st;
  crbd_pkg::out_item_t      step_result;
  crbd_pkg::out_item_t      out_item_r;
  logic                     step_emit;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     in_xfer;
  logic                     out_load;

  crbd_step #(
    .MAX_ANALOG  (MAX_ANALOG),
    .MAX_DIGITAL (MAX_DIGITAL)
  ) u_step (
    .st_i     (st_r),
    .item_i   (in_item),
    .cfg_i    (cfg_r),
    .st_o     (step_st),
    .emit_o   (step_emit),
    .result_o (step_result)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        crbd_pkg::REG_SAMPLE_FORMAT: cfg_nxt.sample_format = cfg_wdata[crbd_pkg::FMT_W-1:0];
        crbd_pkg::REG_ANALOG_COUNT:  cfg_nxt.analog_count  = cfg_wdata[crbd_pkg::ACNT_W-1:0];
        crbd_pkg::REG_DIGITAL_COUNT: cfg_nxt.digital_count = cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output register drains in the same cycle it is refilled.
  assign in_stall      = out_valid_r & out_stall;
  assign in_xfer       = in_valid & ~in_stall;
  assign out_load      = in_xfer & step_emit;
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);
  assign st_nxt        = in_xfer ? step_st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  a_field_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (st_r.byte_position == 2'd0))
    else $error("byte position not cleared after a completed field");

  a_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.byte_position == 2'd0) |-> (st_r.partial_bytes == '0))
    else $error("stale partial bytes at field start");

  a_record_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && step_result.record_last) |=>
      (st_r.field_phase == crbd_pkg::PH_SAMPLE && st_r.field_counter == '0))
    else $error("record end did not return to the sample number");
`endif

endmodule
